[hdl/kmp_pkg.sv]
// Shared types and codes for the streaming KMP matcher.
package kmp_pkg;

  localparam int POS_W = 32;

  typedef enum logic [1:0] {
    OP_CLEAR  = 2'd0,
    OP_APPEND = 2'd1,
    OP_TEXT   = 2'd2,
    OP_END    = 2'd3
  } op_e;

  // match_mode register codes; any other value behaves as first-match
  localparam logic [1:0] MODE_ALL      = 2'd0;
  localparam logic [1:0] MODE_DISJOINT = 2'd1;

  // register index taken from the word address
  localparam logic REG_MATCH_MODE = 1'b0;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_APP_LOAD,
    ST_APP_WALK,
    ST_TXT_WALK,
    ST_TXT_LINK,
    ST_EMIT
  } state_e;

endpackage

[hdl/kmp_in_if.sv]
// Request channel: pattern edits, text bytes and end-of-text markers.
interface kmp_in_if;
  import kmp_pkg::*;

  logic       valid;
  logic       ready;
  op_e        operation;
  logic [7:0] data_byte;

  modport source (output valid, output operation, output data_byte, input ready);
  modport sink   (input valid, input operation, input data_byte, output ready);
endinterface

[hdl/kmp_out_if.sv]
// Result channel: match reports and end-of-text summaries.
interface kmp_out_if;
  import kmp_pkg::*;

  logic             valid;
  logic             ready;
  logic             is_summary;
  logic [POS_W-1:0] match_position;
  logic             found;

  modport source (output valid, output is_summary, output match_position, output found,
                  input ready);
  modport sink   (input valid, input is_summary, input match_position, input found,
                  output ready);
endinterface

[hdl/kmp_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module kmp_ram #(
  parameter int WIDTH  = 8,
  parameter int DEPTH  = 64,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[hdl/kmp_stream_matcher.sv]
// Streaming KMP matcher: pattern and failure links in RAM, walked one link per cycle.
// Clear empties the pattern. Append writes the first byte and its link directly, drops
// a byte when the pattern is full, else loads the failure link and walks the links. A text
// byte is only counted when the pattern is empty or the search stopped, else it walks the
// links, reads the full pattern's link after an overlapping match and hands over any result.
// Links are amortized to about two per byte. Async active-low reset clears control
// state; pattern and failure RAMs are not cleared and are only read after being written.
module kmp_stream_matcher #(
  parameter int PATTERN_MAX     = 64,
  parameter int TEXT_INDEX_BITS = 32
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  kmp_in_if.sink            in_i,
  kmp_out_if.source         out_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [2:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);
  import kmp_pkg::*;

  localparam int IW   = $clog2(PATTERN_MAX + 1);
  localparam int AW_P = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;
  localparam int CW   = (TEXT_INDEX_BITS > IW) ? TEXT_INDEX_BITS : IW;
  localparam int TB   = TEXT_INDEX_BITS;

  state_e state_q, state_d;

  logic [1:0]    mode_q;
  logic [IW-1:0] len_q, len_d;
  logic [IW-1:0] mi_q, mi_d;
  logic [TB-1:0] tc_q, tc_d;
  logic          found_q, found_d;
  logic          stop_q, stop_d;

  logic [IW-1:0] j_q, j_d;
  logic [7:0]    byte_q, byte_d;
  logic [CW-1:0] start_q, start_d;

  logic             res_sum_q, res_sum_d;
  logic [POS_W-1:0] res_pos_q, res_pos_d;
  logic             res_found_q, res_found_d;

  logic             out_valid_q, out_valid_d;
  logic             out_sum_q, out_sum_d;
  logic [POS_W-1:0] out_pos_q, out_pos_d;
  logic             out_found_q, out_found_d;

  // RAM ports
  logic [IW-1:0] rd_addr;
  logic          pat_we;
  logic [7:0]    pat_rdata;
  logic          fail_we;
  logic [IW-1:0] fail_wdata;
  logic [IW-1:0] fail_rdata;

  logic                in_fire;
  logic                out_free;
  logic                pat_eq;
  logic                walk_end;
  logic [IW-1:0]       j_end;
  logic [IW-1:0]       len_inc;
  logic                is_match;
  logic [CW-1:0]       tc_ext;
  logic [CW-1:0]       lenm1_ext;
  logic [CW-1:0]       start_calc;
  logic [POS_W+CW-1:0] start_wide;
  logic                cfg_we;

  kmp_ram #(.WIDTH(8), .DEPTH(PATTERN_MAX), .ADDR_W(AW_P)) u_pattern_ram (
    .clk_i   (clk_i),
    .we_i    (pat_we),
    .waddr_i (len_q[AW_P-1:0]),
    .wdata_i (in_i.data_byte),
    .raddr_i (rd_addr[AW_P-1:0]),
    .rdata_o (pat_rdata)
  );

  kmp_ram #(.WIDTH(IW), .DEPTH(PATTERN_MAX + 1), .ADDR_W(IW)) u_failure_ram (
    .clk_i   (clk_i),
    .we_i    (fail_we),
    .waddr_i (len_inc),
    .wdata_i (fail_wdata),
    .raddr_i (rd_addr),
    .rdata_o (fail_rdata)
  );

  // Configuration port
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && (paddr[2] == REG_MATCH_MODE);
  assign prdata = (paddr[2] == REG_MATCH_MODE) ? {30'd0, mode_q} : 32'd0;

  // Shared conditions
  assign in_i.ready = (state_q == ST_IDLE);
  assign in_fire    = in_i.valid && in_i.ready;
  assign out_free   = !out_valid_q || out_o.ready;
  assign pat_eq     = (pat_rdata == byte_q);
  // a mismatch at entry zero falls to the -1 link and ends the walk
  assign walk_end   = pat_eq || (j_q == '0);
  assign j_end      = pat_eq ? (j_q + IW'(1)) : '0;
  assign len_inc    = len_q + IW'(1);
  assign is_match   = (j_end == len_q);

  // start of a match ending at the current byte: pos + 1 - len, floored at zero
  assign tc_ext     = CW'(tc_q);
  assign lenm1_ext  = CW'(len_q - IW'(1));
  assign start_calc = (tc_ext >= lenm1_ext) ? (tc_ext - lenm1_ext) : '0;
  assign start_wide = {{POS_W{1'b0}}, start_q};

  assign out_o.valid          = out_valid_q;
  assign out_o.is_summary     = out_sum_q;
  assign out_o.match_position = out_pos_q;
  assign out_o.found          = out_found_q;

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          unique case (in_i.operation)
            OP_CLEAR: state_d = ST_IDLE;
            OP_APPEND: begin
              if (len_q != IW'(PATTERN_MAX) && len_q != '0) begin
                state_d = ST_APP_LOAD;
              end
            end
            OP_TEXT: begin
              if (len_q != '0 && !stop_q) begin
                state_d = ST_TXT_WALK;
              end
            end
            OP_END: state_d = ST_EMIT;
          endcase
        end
      end
      ST_APP_LOAD: state_d = ST_APP_WALK;
      ST_APP_WALK: begin
        if (walk_end) begin
          state_d = ST_IDLE;
        end
      end
      ST_TXT_WALK: begin
        if (walk_end) begin
          if (!is_match) begin
            state_d = ST_IDLE;
          end else if (mode_q == MODE_ALL) begin
            state_d = ST_TXT_LINK;
          end else begin
            state_d = ST_EMIT;
          end
        end
      end
      ST_TXT_LINK: state_d = ST_EMIT;
      ST_EMIT: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Datapath and memory control
  always_comb begin
    len_d       = len_q;
    mi_d        = mi_q;
    tc_d        = tc_q;
    found_d     = found_q;
    stop_d      = stop_q;
    j_d         = j_q;
    byte_d      = byte_q;
    start_d     = start_q;
    res_sum_d   = res_sum_q;
    res_pos_d   = res_pos_q;
    res_found_d = res_found_q;
    out_sum_d   = out_sum_q;
    out_pos_d   = out_pos_q;
    out_found_d = out_found_q;
    out_valid_d = out_valid_q && !out_o.ready;
    rd_addr     = j_q;
    pat_we      = 1'b0;
    fail_we     = 1'b0;
    fail_wdata  = j_end;

    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          unique case (in_i.operation)
            OP_CLEAR: begin
              len_d = '0;
              mi_d  = '0;
            end
            OP_APPEND: begin
              rd_addr = len_q;
              byte_d  = in_i.data_byte;
              if (len_q != IW'(PATTERN_MAX)) begin
                pat_we = 1'b1;
                mi_d   = '0;
                // first byte: its link is known without a walk
                if (len_q == '0) begin
                  fail_we    = 1'b1;
                  fail_wdata = '0;
                  len_d      = len_inc;
                end
              end
            end
            OP_TEXT: begin
              rd_addr = mi_q;
              j_d     = mi_q;
              byte_d  = in_i.data_byte;
              start_d = start_calc;
              if (tc_q != {TB{1'b1}}) begin
                tc_d = tc_q + TB'(1);
              end
            end
            OP_END: begin
              res_sum_d   = 1'b1;
              res_pos_d   = '0;
              res_found_d = found_q;
              mi_d        = '0;
              tc_d        = '0;
              found_d     = 1'b0;
              stop_d      = 1'b0;
            end
          endcase
        end
      end
      ST_APP_LOAD: begin
        j_d     = fail_rdata;
        rd_addr = fail_rdata;
      end
      ST_APP_WALK: begin
        if (walk_end) begin
          fail_we = 1'b1;
          len_d   = len_inc;
        end else begin
          j_d     = fail_rdata;
          rd_addr = fail_rdata;
        end
      end
      ST_TXT_WALK: begin
        if (walk_end) begin
          rd_addr = len_q;
          if (is_match) begin
            found_d     = 1'b1;
            res_sum_d   = 1'b0;
            res_pos_d   = start_wide[POS_W-1:0];
            res_found_d = 1'b1;
            mi_d        = '0;
            // modes other than all/disjoint stop after the first report
            if (mode_q != MODE_ALL && mode_q != MODE_DISJOINT) begin
              stop_d = 1'b1;
            end
          end else begin
            mi_d = j_end;
          end
        end else begin
          j_d     = fail_rdata;
          rd_addr = fail_rdata;
        end
      end
      ST_TXT_LINK: begin
        // restart through the link of the full pattern
        mi_d = fail_rdata;
      end
      ST_EMIT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_sum_d   = res_sum_q;
          out_pos_d   = res_pos_q;
          out_found_d = res_found_q;
        end
      end
      default: begin
        rd_addr = j_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      mode_q      <= MODE_ALL;
      len_q       <= '0;
      mi_q        <= '0;
      tc_q        <= '0;
      found_q     <= 1'b0;
      stop_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      len_q       <= len_d;
      mi_q        <= mi_d;
      tc_q        <= tc_d;
      found_q     <= found_d;
      stop_q      <= stop_d;
      out_valid_q <= out_valid_d;
      if (cfg_we) begin
        mode_q <= pwdata[1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    j_q         <= j_d;
    byte_q      <= byte_d;
    start_q     <= start_d;
    res_sum_q   <= res_sum_d;
    res_pos_q   <= res_pos_d;
    res_found_q <= res_found_d;
    out_sum_q   <= out_sum_d;
    out_pos_q   <= out_pos_d;
    out_found_q <= out_found_d;
  end

endmodule

[bench/tb.sv]
// Self-checking bench for kmp_stream_matcher: directed, random and stall tests.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import kmp_pkg::*;

  localparam int PAT_MAX      = 64;
  localparam int SETTLE       = 160;
  localparam int STALL_LIMIT  = 3000;
  localparam int REPORT_LIMIT = 10;

  // mode codes beyond the two that the package names
  localparam logic [1:0] MODE_FIRST = 2'd2;
  localparam logic [1:0] MODE_SPARE = 2'd3;
  localparam logic [2:0] MODE_ADDR  = {REG_MATCH_MODE, 2'b00};

  typedef struct packed {
    logic        is_summary;
    logic [31:0] match_position;
    logic        found;
  } match_rec_t;

  logic        clk_i;
  logic        rst_ni;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  kmp_in_if  in_ch ();
  kmp_out_if out_ch ();

  kmp_stream_matcher #(
    .PATTERN_MAX    (PAT_MAX),
    .TEXT_INDEX_BITS(32)
  ) uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready)
  );

  // predictor state
  logic [7:0]  pat_mem [PAT_MAX];
  int          fail_link [PAT_MAX+1];
  int          pat_len = 0;
  int          match_at = 0;
  logic [31:0] text_idx = '0;
  bit          any_found = 0;
  bit          search_done = 0;
  logic [1:0]  cur_mode = MODE_ALL;

  match_rec_t  pending_results [$];
  int          mismatch_count = 0;
  int          items_sent = 0;
  int          reports_seen = 0;
  int          summaries_seen = 0;
  int          hold_cycles = 0;
  int          quiet_cycles = 0;
  bit          idle_on = 1;

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  function automatic void kmp_predict(op_e op, logic [7:0] b);
    int n;
    int j;
    longint unsigned start;
    logic [31:0] pos;
    case (op)
      OP_CLEAR: begin
        pat_len  = 0;
        match_at = 0;
      end
      OP_APPEND: begin
        if (pat_len < PAT_MAX) begin
          n = pat_len;
          pat_mem[n] = b;
          j = fail_link[n];
          pat_len = n + 1;
          while (j >= 0 && j < n && pat_mem[j] != b) j = fail_link[j];
          fail_link[n+1] = j + 1;
          match_at = 0;
        end
      end
      OP_END: begin
        pending_results.push_back('{1'b1, 32'd0, any_found});
        match_at    = 0;
        text_idx    = '0;
        any_found   = 0;
        search_done = 0;
      end
      default: begin
        pos = text_idx;
        if (text_idx != '1) text_idx++;
        if (pat_len != 0 && !search_done) begin
          j = match_at;
          while (j >= 0 && j < pat_len && pat_mem[j] != b) j = fail_link[j];
          j++;
          if (j >= pat_len) begin
            start = longint'(pos) + 1;
            start = (start >= pat_len) ? start - pat_len : 0;
            pending_results.push_back('{1'b0, start[31:0], 1'b1});
            any_found = 1;
            case (cur_mode)
              MODE_ALL:      j = fail_link[pat_len];
              MODE_DISJOINT: j = 0;
              default: begin
                j = 0;
                search_done = 1;
              end
            endcase
          end
          match_at = j;
        end
      end
    endcase
  endfunction

  // offer one request, hold it until taken, then update the prediction
  task automatic send_item(op_e op, logic [7:0] b);
    int gap;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 8);
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_ch.valid     <= 1'b1;
    in_ch.operation <= op;
    in_ch.data_byte <= b;
    do @(posedge clk_i); while (!in_ch.ready);
    kmp_predict(op, b);
    items_sent++;
  endtask

  // stop sending and let every outstanding result and link walk finish
  task automatic wait_results_done();
    in_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic load_match_mode(logic [1:0] mode);
    logic [31:0] wdata;
    logic [31:0] rdata;
    wait_results_done();
    wdata = {$urandom_range(0, 1) ? 30'($urandom()) : 30'd0, mode};
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= MODE_ADDR;
    pwdata  <= wdata;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    cur_mode = wdata[1:0];
    // read back
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    rdata = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    if (rdata[1:0] != mode) begin
      mismatch_count++;
      if (mismatch_count <= REPORT_LIMIT)
        $display("match_mode readback: expected %0d, got %0d", mode, rdata[1:0]);
    end
  endtask

  task automatic test_directed();
    send_item(OP_TEXT, 8'h00);
    send_item(OP_END, 8'hFF);
    send_item(OP_APPEND, 8'hFF);
    send_item(OP_APPEND, 8'h00);
    send_item(OP_APPEND, 8'hFF);
    send_item(OP_TEXT, 8'hFF);
    send_item(OP_TEXT, 8'h00);
    send_item(OP_TEXT, 8'hFF);
    send_item(OP_TEXT, 8'h00);
    send_item(OP_TEXT, 8'hFF);
    // grow the pattern mid-text: match restarts, position keeps counting
    send_item(OP_APPEND, 8'h00);
    send_item(OP_TEXT, 8'hFF);
    send_item(OP_TEXT, 8'h00);
    send_item(OP_TEXT, 8'hFF);
    send_item(OP_TEXT, 8'h00);
    send_item(OP_END, 8'h00);
    send_item(OP_CLEAR, 8'h00);
    send_item(OP_TEXT, 8'h5A);
    send_item(OP_END, 8'h00);
  endtask

  task automatic test_full_pattern();
    send_item(OP_CLEAR, 8'hA5);
    repeat (PAT_MAX - 1) send_item(OP_APPEND, 8'h61);
    send_item(OP_APPEND, 8'h62);
    // pattern is full, these are dropped
    send_item(OP_APPEND, 8'h63);
    send_item(OP_APPEND, 8'h61);
    repeat (70) send_item(OP_TEXT, 8'h61);
    send_item(OP_TEXT, 8'h62);
    repeat (PAT_MAX - 1) send_item(OP_TEXT, 8'h61);
    send_item(OP_TEXT, 8'h62);
    send_item(OP_END, 8'h00);
  endtask

  task automatic test_random(int n_items);
    logic [7:0] sym [3];
    logic [7:0] pat [$];
    logic [7:0] b;
    int stop_at;
    int nsym;
    int plen;
    int tlen;
    stop_at = items_sent + n_items;
    nsym = 1;
    while (items_sent < stop_at) begin
      if ($urandom_range(0, 9) == 0) begin
        send_item(op_e'($urandom_range(0, 3)), 8'($urandom()));
        pat.delete();
        continue;
      end
      if (pat.size() == 0 || $urandom_range(0, 3) != 0) begin
        for (int i = 0; i < 3; i++) sym[i] = 8'($urandom());
        nsym = $urandom_range(1, 3);
        send_item(OP_CLEAR, 8'($urandom()));
        pat.delete();
        plen = ($urandom_range(0, 39) == 0) ? $urandom_range(60, 66) : $urandom_range(1, 6);
        repeat (plen) begin
          b = sym[$urandom_range(0, nsym - 1)];
          send_item(OP_APPEND, b);
          if (pat.size() < PAT_MAX) pat.push_back(b);
        end
      end
      tlen = $urandom_range(0, 40);
      repeat (tlen) begin
        if ($urandom_range(0, 11) == 0) begin
          foreach (pat[i]) send_item(OP_TEXT, pat[i]);
        end else if ($urandom_range(0, 49) == 0) begin
          b = sym[$urandom_range(0, nsym - 1)];
          send_item(OP_APPEND, b);
          if (pat.size() < PAT_MAX) pat.push_back(b);
        end else begin
          b = ($urandom_range(0, 19) == 0) ? 8'($urandom()) : sym[$urandom_range(0, nsym - 1)];
          send_item(OP_TEXT, b);
        end
      end
      if ($urandom_range(0, 9) != 0) send_item(OP_END, 8'($urandom()));
    end
  endtask

  // single-byte pattern: every text byte matches, so results pile up behind a held sink
  task automatic test_backpressure();
    send_item(OP_CLEAR, 8'h00);
    send_item(OP_APPEND, 8'h3C);
    hold_cycles = 400;
    repeat (30) send_item(OP_TEXT, 8'h3C);
    send_item(OP_END, 8'h00);
    wait_results_done();
  endtask

  // result sink with random stall bursts and a long hold on request
  initial begin
    int stall_left;
    stall_left = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_cycles > 0) begin
        out_ch.ready <= 1'b0;
        hold_cycles--;
      end else if (stall_left > 0) begin
        out_ch.ready <= 1'b0;
        stall_left--;
      end else if (idle_on && $urandom_range(0, 4) == 0) begin
        stall_left = $urandom_range(0, 7);
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    match_rec_t want;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      if (out_ch.is_summary) summaries_seen++;
      else reports_seen++;
      if (pending_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT)
          $display("unexpected result: summary=%0d pos=%0d found=%0d",
                   out_ch.is_summary, out_ch.match_position, out_ch.found);
      end else begin
        want = pending_results.pop_front();
        if (out_ch.is_summary !== want.is_summary ||
            out_ch.match_position !== want.match_position ||
            out_ch.found !== want.found) begin
          mismatch_count++;
          if (mismatch_count <= REPORT_LIMIT)
            $display("result mismatch: expected summary=%0d pos=%0d found=%0d, got %0d %0d %0d",
                     want.is_summary, want.match_position, want.found,
                     out_ch.is_summary, out_ch.match_position, out_ch.found);
        end
      end
    end
  end

  // watchdog: end the run when nothing moves for too long
  always @(posedge clk_i) begin
    if (!rst_ni || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (psel && penable && pready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("timeout after %0d idle cycles", quiet_cycles);
        $display("kmp_stream_matcher verification failed");
        $finish;
      end
    end
  end

  initial begin
    for (int i = 0; i <= PAT_MAX; i++) fail_link[i] = 0;
    fail_link[0] = -1;
    rst_ni          = 1'b0;
    in_ch.valid     = 1'b0;
    in_ch.operation = OP_CLEAR;
    in_ch.data_byte = 8'h00;
    psel            = 1'b0;
    penable         = 1'b0;
    pwrite          = 1'b0;
    paddr           = '0;
    pwdata          = '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_full_pattern();
    load_match_mode(MODE_DISJOINT);
    test_random(300);
    load_match_mode(MODE_FIRST);
    test_random(300);
    load_match_mode(MODE_SPARE);
    test_random(200);
    load_match_mode(MODE_ALL);
    test_backpressure();
    idle_on = 0;
    test_random(250);
    wait_results_done();

    if (pending_results.size() != 0) begin
      mismatch_count++;
      $display("%0d expected results never arrived", pending_results.size());
    end
    $display("Covered %0d requests in all four match modes, full and overflowing patterns,",
             items_sent);
    $display("a long result hold; checked %0d match reports and %0d summaries.",
             reports_seen, summaries_seen);
    if (mismatch_count == 0) begin
      $display("kmp_stream_matcher verification clean");
    end else begin
      $display("%0d mismatches", mismatch_count);
      $display("kmp_stream_matcher verification failed");
    end
    $finish;
  end

endmodule

[files.f]
hdl/kmp_pkg.sv
hdl/kmp_in_if.sv
hdl/kmp_out_if.sv
hdl/kmp_ram.sv
hdl/kmp_stream_matcher.sv
bench/tb.sv
